[rtl/core/spq_pkg.sv]
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 3;
  localparam int TAG_BITS_DEF  = 16;

  // transaction kind
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

endpackage

[rtl/core/spq_if.sv]
interface spq_in_if import spq_pkg::*; #(
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [PRIO_BITS-1:0] priority_req;
  logic [TAG_BITS-1:0]  tag;

  modport source (output valid, kind, priority_req, tag, input ready);
  modport sink   (input valid, kind, priority_req, tag, output ready);
endinterface

interface spq_out_if import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 valid;
  logic                 ready;
  spq_status_t          status;
  logic [TAG_BITS-1:0]  out_tag;
  logic [PRIO_BITS-1:0] out_priority;
  logic [CNT_W-1:0]     occupancy;

  modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

[rtl/core/stable_priority_queue_core.sv]
// Stable bounded priority queue. Each input transaction is an insert
// (priority, tag) or a remove of the head entry; each gives exactly one
// result transaction with a status, the removed entry (zero otherwise) and
// the occupancy after the operation. Lower priority values leave first and
// equal priorities leave in arrival order. Entries live in one DEPTH-deep
// synchronous RAM used as a ring (head pointer plus count) with one read
// and one write port. One transaction is in work at a time: a remove reads
// the head cell and then moves to S_FINISH; an insert into a full queue, an
// insert into an empty queue or a remove from an empty one goes straight to
// S_FINISH; any other successful insert walks down from the tail and shifts
// up one slot every stored entry with a strictly greater priority value, one
// RAM cell per cycle, before it writes the new entry. A result waits in
// S_FINISH until the output register is free. The output register lets the
// next transaction be accepted while a result still waits to be taken.
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CELL_W = PRIO_BITS + TAG_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_PUT,
    S_REM_RD,
    S_FINISH
  } state_t;

  // ring index: base + offset, wrapped once at DEPTH
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W+1)'(DEPTH)) s = s - (IDX_W+1)'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  // entry storage
  logic [CELL_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  state_t               state_r,    state_nxt;
  logic [IDX_W-1:0]     head_r,     head_nxt;
  logic [CNT_W-1:0]     count_r,    count_nxt;
  logic [IDX_W-1:0]     k_r,        k_nxt;      // slot to fill during insert scan
  logic [PRIO_BITS-1:0] ins_prio_r, ins_prio_nxt;
  logic [TAG_BITS-1:0]  ins_tag_r,  ins_tag_nxt;
  spq_status_t          res_st_r,   res_st_nxt;   // pending result
  logic [TAG_BITS-1:0]  res_tag_r,  res_tag_nxt;
  logic [PRIO_BITS-1:0] res_prio_r, res_prio_nxt;
  logic                 out_valid_r, out_valid_nxt;
  spq_status_t          out_st_r,   out_st_nxt;
  logic [TAG_BITS-1:0]  out_tag_r,  out_tag_nxt;
  logic [PRIO_BITS-1:0] out_prio_r, out_prio_nxt;
  logic [CNT_W-1:0]     out_occ_r,  out_occ_nxt;

  logic                 in_fire;
  logic [PRIO_BITS-1:0] cell_prio;
  logic [CELL_W-1:0]    new_cell;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cell_prio   = rd_data_r[CELL_W-1:TAG_BITS];
  assign new_cell    = {ins_prio_r, ins_tag_r};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    ins_prio_nxt  = ins_prio_r;
    ins_tag_nxt   = ins_tag_r;
    res_st_nxt    = res_st_r;
    res_tag_nxt   = res_tag_r;
    res_prio_nxt  = res_prio_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_tag_nxt   = out_tag_r;
    out_prio_nxt  = out_prio_r;
    out_occ_nxt   = out_occ_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ins_prio_nxt = in_ch.priority_req;
          ins_tag_nxt  = in_ch.tag;
          res_tag_nxt  = '0;
          res_prio_nxt = '0;
          res_st_nxt   = ST_OK;
          if (in_ch.kind == KIND_INSERT) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_FINISH;
            end else if (count_r == '0) begin
              mem_we    = 1'b1;
              mem_waddr = head_r;
              mem_wdata = {in_ch.priority_req, in_ch.tag};
              count_nxt = CNT_W'(1);
              state_nxt = S_FINISH;
            end else begin
              // walk down from the tail
              k_nxt     = count_r[IDX_W-1:0];
              mem_re    = 1'b1;
              mem_raddr = phys(head_r, IDX_W'(count_r - 1'b1));
              state_nxt = S_INS_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_FINISH;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_r;
              state_nxt = S_REM_RD;
            end
          end
        end
      end

      S_INS_SCAN: begin
        // rd_data_r holds logical cell k_r-1
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, k_r);
        if (cell_prio > ins_prio_r) begin
          mem_wdata = rd_data_r;
          k_nxt     = k_r - 1'b1;
          if (k_r == IDX_W'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_r, k_r - IDX_W'(2));
          end
        end else begin
          mem_wdata = new_cell;
          count_nxt = count_r + 1'b1;
          state_nxt = S_FINISH;
        end
      end

      S_INS_PUT: begin
        // new entry becomes the head
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, k_r);
        mem_wdata = new_cell;
        count_nxt = count_r + 1'b1;
        state_nxt = S_FINISH;
      end

      S_REM_RD: begin
        res_tag_nxt  = rd_data_r[TAG_BITS-1:0];
        res_prio_nxt = cell_prio;
        head_nxt     = phys(head_r, IDX_W'(1));
        count_nxt    = count_r - 1'b1;
        state_nxt    = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_tag_nxt   = res_tag_r;
          out_prio_nxt  = res_prio_r;
          out_occ_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    ins_prio_r <= ins_prio_nxt;
    ins_tag_r  <= ins_tag_nxt;
    res_st_r   <= res_st_nxt;
    res_tag_r  <= res_tag_nxt;
    res_prio_r <= res_prio_nxt;
    out_st_r   <= out_st_nxt;
    out_tag_r  <= out_tag_nxt;
    out_prio_r <= out_prio_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.out_tag      = out_tag_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.occupancy    = out_occ_r;

endmodule
